// ===== design/byte_ring_fifo_with_peek_macros.svh =====
// Assertion helpers. Each macro expands to one labeled concurrent assertion
// clocked on clk and disabled while rst_n is low.
`ifndef BYTE_RING_FIFO_WITH_PEEK_MACROS_SVH
`define BYTE_RING_FIFO_WITH_PEEK_MACROS_SVH

// same-cycle implication
`define BRF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brf assertion failed");

// next-cycle implication
`define BRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brf assertion failed");

`endif

// ===== design/brf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

  localparam int DEPTH    = 256;
  localparam int MAX_PEEK = 64;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PEEK_W = $clog2(MAX_PEEK + 1);
  localparam int IDX_W  = (MAX_PEEK > 1) ? $clog2(MAX_PEEK) : 1;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_SKIP  = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam int REG_CAPACITY = 0;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_in;
    logic [8:0] count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic [8:0] fill_level;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    K_PUSH,
    K_POP,
    K_PEEK,
    K_SKIP,
    K_FLUSH,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [8:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== design/brf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/brf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brf_front import brf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_take
);

  // two-entry command queue
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.data  = in_item.data_in;
    cls.count = in_item.count;
    unique case (in_item.op)
      OP_PUSH:  cls.kind = K_PUSH;
      OP_POP:   cls.kind = K_POP;
      OP_PEEK:  cls.kind = K_PEEK;
      OP_SKIP:  cls.kind = K_SKIP;
      OP_FLUSH: cls.kind = K_FLUSH;
      default:  cls.kind = K_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== design/brf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brf_back import brf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] cap,
  input  wire logic             clear,
  input  wire logic             cmd_valid,
  input  wire cmd_t             cmd,
  output logic                  cmd_take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item
);

  back_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [PTR_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [PEEK_W-1:0] n_r, n_nxt;
  logic             is_pop_r, is_pop_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             slot_free;
  logic             ram_we;
  logic [7:0]       ram_q;
  logic [CNT_W-1:0] m;
  logic [PTR_W+1:0] skip_sum;
  logic             last_byte;

  function automatic logic [PTR_W-1:0] adv(logic [PTR_W-1:0] p, logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] s;
    s = {{(CNT_W-PTR_W){1'b0}}, p} + CNT_W'(1);
    return (s == c) ? '0 : s[PTR_W-1:0];
  endfunction

  brf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wp_r),
    .wr_data (cmd.data),
    .rd_addr (pos_r),
    .rd_data (ram_q)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign m         = (cmd.count < held_r) ? cmd.count : held_r;
  assign skip_sum  = {2'b00, rp_r} + {1'b0, m};
  assign last_byte = ({1'b0, idx_r} == (n_r - PEEK_W'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free && held_r != '0) begin
          if (cmd.kind == K_POP) begin
            state_nxt = S_READ;
          end else if (cmd.kind == K_PEEK && cmd.count != '0) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = last_byte ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    is_pop_nxt    = is_pop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    cmd_take      = 1'b0;
    ram_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_take           = 1'b1;
          out_valid_nxt      = 1'b1;
          out_nxt.data_out   = '0;
          out_nxt.status     = ST_OK;
          out_nxt.fill_level = held_r;
          out_nxt.last       = 1'b1;
          pos_nxt            = rp_r;
          idx_nxt            = '0;
          case (cmd.kind)
            K_PUSH: begin
              if (held_r >= cap) begin
                out_nxt.status = ST_FULL;
              end else begin
                ram_we             = 1'b1;
                wp_nxt             = adv(wp_r, cap);
                held_nxt           = held_r + CNT_W'(1);
                out_nxt.fill_level = held_r + CNT_W'(1);
              end
            end
            K_POP: begin
              if (held_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                out_nxt       = out_r;
                is_pop_nxt    = 1'b1;
                n_nxt         = PEEK_W'(1);
              end
            end
            K_PEEK: begin
              if (held_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else if (cmd.count == '0) begin
                out_nxt.status = ST_ZERO;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                out_nxt       = out_r;
                is_pop_nxt    = 1'b0;
                n_nxt         = (m > CNT_W'(MAX_PEEK)) ? PEEK_W'(MAX_PEEK) : m[PEEK_W-1:0];
              end
            end
            K_SKIP: begin
              if (held_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else if (cmd.count == '0) begin
                out_nxt.status = ST_ZERO;
              end else begin
                // rp + m stays below twice the ring size
                rp_nxt = (skip_sum >= {1'b0, cap}) ?
                         PTR_W'(skip_sum - {1'b0, cap}) : skip_sum[PTR_W-1:0];
                held_nxt           = held_r - m;
                out_nxt.fill_level = held_r - m;
              end
            end
            K_FLUSH: begin
              rp_nxt             = '0;
              wp_nxt             = '0;
              held_nxt           = '0;
              out_nxt.fill_level = '0;
            end
            default: ;
          endcase
        end
      end
      S_READ: ;
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.data_out   = ram_q;
          out_nxt.status     = ST_OK;
          out_nxt.last       = last_byte;
          out_nxt.fill_level = held_r;
          if (is_pop_r) begin
            rp_nxt             = adv(rp_r, cap);
            held_nxt           = held_r - CNT_W'(1);
            out_nxt.fill_level = held_r - CNT_W'(1);
          end
          idx_nxt = idx_r + IDX_W'(1);
          pos_nxt = adv(pos_r, cap);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (clear) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      out_valid_r <= out_valid_nxt;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    n_r      <= n_nxt;
    is_pop_r <= is_pop_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ===== design/byte_ring_fifo_with_peek.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                  Payload
// in_*      input      in_valid / in_stall        in_item_t  (op, data_in, count)
// out_*     output     out_valid / out_stall      out_item_t (data_out, status,
//                                                 fill_level, last)
// config    input      psel/penable/pwrite/pready capacity register at 0x0
//
// Push, flush, skip, nop and every failed op finish in the executor's idle state.
// Pop passes through issue, RAM read and emit; peek issues, then repeats RAM read
// and emit per byte, as the byte store has a single registered read port.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 256.
// A two-entry command queue lets the input side keep taking items while the
// executor waits on a stalled output; out_stall freezes only the executor.
module byte_ring_fifo_with_peek import brf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input channel
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  // result channel
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  // configuration port
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

`include "byte_ring_fifo_with_peek_macros.svh"

  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic             cfg_wr;
  logic             cap_wr;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_take;

  // register file: only capacity, at word 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cap_wr = cfg_wr && (paddr[2] == 1'(REG_CAPACITY));
  assign cap_nxt = cap_wr ? pwdata[CNT_W-1:0] : cap_r;
  assign prdata = (paddr[2] == 1'(REG_CAPACITY)) ? {{(32-CNT_W){1'b0}}, cap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(DEPTH);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // zero acts as one slot, anything past the store size as the full store
  assign cap_eff = (cap_r == '0) ? CNT_W'(1) :
                   (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;

  // front: accept and classify into the command queue
  brf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: pointers, byte store, result register
  brf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap_eff),
    .clear     (cap_wr),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a result never reports more bytes than the ring holds
  `BRF_ASSERT_IMPL(a_fill_in_range, out_valid, out_item.fill_level <= cap_eff)
  // failed ops give exactly one result
  `BRF_ASSERT_IMPL(a_fail_is_last, out_valid && out_item.status != ST_OK, out_item.last)
  // a peek that goes on past this byte leaves the queue non-empty
  `BRF_ASSERT_IMPL(a_peek_nonempty, out_valid && !out_item.last,
                   out_item.status == ST_OK && out_item.fill_level != '0)
  // commands leave the queue only when the queue holds one
  `BRF_ASSERT_IMPL(a_take_valid, cmd_take, cmd_valid)

endmodule
`default_nettype wire

// ===== tb/sv/brf_result_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels and the register port, keeps a shadow copy of the
// ring and compares every result transfer against the oldest prediction.
module brf_result_checker import brf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_item_t    in_item,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_item_t   out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);

  logic [7:0]  ring_bytes [0:DEPTH-1];
  int unsigned rd_idx;
  int unsigned wr_idx;
  int unsigned held;
  int unsigned cap_setting;
  out_item_t   expected_results [$];

  // zero behaves as one slot, anything above DEPTH as DEPTH
  function automatic int unsigned ring_size();
    int unsigned c;
    c = cap_setting;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic void add_result(input logic [7:0] d, input logic [1:0] st,
                                     input logic lst);
    out_item_t r;
    r.data_out   = d;
    r.status     = st;
    r.fill_level = 9'(held);
    r.last       = lst;
    expected_results.push_back(r);
  endfunction

  task automatic predict_fifo_results(input in_item_t it);
    int unsigned cap;
    int unsigned cnt;
    int unsigned n;
    logic [7:0]  b;
    cap = ring_size();
    cnt = 32'(it.count);
    case (it.op)
      OP_PUSH: begin
        if (held >= cap) begin
          add_result(8'd0, ST_FULL, 1'b1);
        end else begin
          ring_bytes[PTR_W'(wr_idx)] = it.data_in;
          wr_idx = (wr_idx + 1) % cap;
          held++;
          add_result(8'd0, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (held == 0) begin
          add_result(8'd0, ST_EMPTY, 1'b1);
        end else begin
          b = ring_bytes[PTR_W'(rd_idx)];
          rd_idx = (rd_idx + 1) % cap;
          held--;
          add_result(b, ST_OK, 1'b1);
        end
      end
      OP_PEEK, OP_SKIP: begin
        // empty wins over zero count
        if (held == 0) begin
          add_result(8'd0, ST_EMPTY, 1'b1);
        end else if (cnt == 0) begin
          add_result(8'd0, ST_ZERO, 1'b1);
        end else begin
          n = (cnt < held) ? cnt : held;
          if (it.op == OP_PEEK) begin
            if (n > MAX_PEEK) n = MAX_PEEK;
            for (int unsigned i = 0; i < n; i++)
              add_result(ring_bytes[PTR_W'((rd_idx + i) % cap)], ST_OK, (i + 1 == n));
          end else begin
            rd_idx = (rd_idx + n) % cap;
            held -= n;
            add_result(8'd0, ST_OK, 1'b1);
          end
        end
      end
      OP_FLUSH: begin
        rd_idx = 0;
        wr_idx = 0;
        held   = 0;
        add_result(8'd0, ST_OK, 1'b1);
      end
      default: add_result(8'd0, ST_OK, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      rd_idx      = 0;
      wr_idx      = 0;
      held        = 0;
      cap_setting = DEPTH;
      expected_results.delete();
      pending     = 0;
      fail_count  = 0;
    end else begin
      // compare first so a result never matches a prediction made this edge
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: data_out %0d status %0d fill_level %0d last %0b",
                 out_item.data_out, out_item.status, out_item.fill_level,
                 out_item.last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.data_out !== want.data_out) begin
            $error("data_out: expected %0d, got %0d", want.data_out, out_item.data_out);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
          if (out_item.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, got %0d", want.fill_level,
                   out_item.fill_level);
            fail_count++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_item.last);
            fail_count++;
          end
        end
      end
      // capacity write at address 0 resets the ring; the checker models no register elsewhere
      if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_CAPACITY)) begin
        cap_setting = 32'(pwdata[8:0]);
        rd_idx      = 0;
        wr_idx      = 0;
        held        = 0;
      end
      if (in_valid && !in_stall) predict_fifo_results(in_item);
      pending = expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict. All prediction and comparison lives in the checker.
module tb_top;
  import brf_pkg::*;

  // shapes of random bursts
  localparam int BURST_FILL  = 0;
  localparam int BURST_DRAIN = 1;
  localparam int BURST_MIXED = 2;

  // cycles allowed after the last result before touching the register
  localparam int SETTLE_CYCLES = 8;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  // when set, neither side idles: gives long back-to-back stretches
  bit calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_ring_fifo_with_peek uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  brf_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver back-pressure: stalled at random with probability 0.09, none while calm.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 9);
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic in_item_t mk(input logic [2:0] op, input logic [7:0] d,
                                  input logic [8:0] c);
    in_item_t it;
    it.op      = op;
    it.data_in = d;
    it.count   = c;
    return it;
  endfunction

  // One transfer on the input channel. Valid is left high after the
  // transfer; the next call (or a drain) decides its value, so only one
  // nonblocking write to in_valid lands in any time step.
  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender until every predicted result has come out, then let
  // the back end settle before anything else happens.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle held until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_capacity(input logic [31:0] value);
    wait_drained();
    write_reg(3'(4 * REG_CAPACITY), value);
  endtask

  // Mostly short peeks and skips; now and then zero, a long one, or the top.
  function automatic logic [8:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 9'd0;
    if (r < 70) return 9'($urandom_range(1, 8));
    if (r < 95) return 9'($urandom_range(1, 256));
    return 9'd256;
  endfunction

  function automatic in_item_t random_item(input int burst);
    in_item_t it;
    int r;
    it.data_in = 8'($urandom);
    it.count   = pick_count();
    r = $urandom_range(0, 99);
    case (burst)
      BURST_FILL:  it.op = (r < 80) ? OP_PUSH : (r < 90) ? OP_POP : OP_PEEK;
      BURST_DRAIN: it.op = (r < 35) ? OP_POP : (r < 65) ? OP_PEEK :
                           (r < 85) ? OP_SKIP : OP_PUSH;
      default:     it.op = (r < 40) ? OP_PUSH : (r < 60) ? OP_POP :
                           (r < 78) ? OP_PEEK : OP_SKIP;
    endcase
    // noise: an occasional flush or unused code
    r = $urandom_range(0, 99);
    if (r < 3) it.op = OP_FLUSH;
    else if (r < 5) it.op = 3'($urandom_range(5, 7));
    return it;
  endfunction

  // Bursts of six items keep the ring swinging between full and empty.
  task automatic run_random_phase(input int n_items, input bit hold_midway);
    int burst;
    burst = BURST_MIXED;
    for (int k = 0; k < n_items; k++) begin
      if (k % 6 == 0) burst = $urandom_range(BURST_FILL, BURST_MIXED);
      if (hold_midway && k == n_items / 2) wait_drained();
      send_item(random_item(burst));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset capacity of 256 ---
    // pop, peek and skip on an empty ring, then three pushes
    send_item(mk(OP_POP,  8'h00, 9'd5));
    send_item(mk(OP_PEEK, 8'h00, 9'd5));
    send_item(mk(OP_SKIP, 8'h00, 9'd5));
    send_item(mk(OP_PUSH, 8'h00, 9'd0));
    send_item(mk(OP_PUSH, 8'hFF, 9'd0));
    send_item(mk(OP_PUSH, 8'hA5, 9'd0));
    // zero count on a non-empty ring, then a peek capped at the length
    send_item(mk(OP_PEEK, 8'h00, 9'd0));
    send_item(mk(OP_SKIP, 8'h00, 9'd0));
    send_item(mk(OP_PEEK, 8'h00, 9'd256));
    send_item(mk(OP_PEEK, 8'h00, 9'd1));
    send_item(mk(OP_SKIP, 8'h00, 9'd1));
    send_item(mk(OP_POP,  8'h00, 9'd0));
    // unused codes leave the ring alone
    send_item(mk(3'd5, 8'h12, 9'd3));
    send_item(mk(3'd7, 8'h34, 9'd3));
    send_item(mk(OP_FLUSH, 8'h00, 9'd0));

    // two slots: full report and pointer wrap
    set_capacity(32'd2);
    send_item(mk(OP_PUSH, 8'h11, 9'd0));
    send_item(mk(OP_PUSH, 8'h22, 9'd0));
    send_item(mk(OP_PUSH, 8'h33, 9'd0));
    send_item(mk(OP_PEEK, 8'h00, 9'd64));
    send_item(mk(OP_POP,  8'h00, 9'd0));
    send_item(mk(OP_PUSH, 8'h44, 9'd0));
    send_item(mk(OP_PEEK, 8'h00, 9'd2));
    send_item(mk(OP_POP,  8'h00, 9'd0));

    // zero behaves as a single slot; write also clears what was held
    set_capacity(32'd0);
    send_item(mk(OP_PUSH, 8'h55, 9'd0));
    send_item(mk(OP_PUSH, 8'h66, 9'd0));
    send_item(mk(OP_POP,  8'h00, 9'd0));

    // largest code with junk above the register width: acts as DEPTH
    set_capacity({23'($urandom), 9'h1FF});
    send_item(mk(OP_PUSH, 8'h77, 9'd0));
    send_item(mk(OP_PUSH, 8'h88, 9'd0));
    // no register at the next word: contents must survive
    wait_drained();
    write_reg(3'd4, $urandom);
    send_item(mk(OP_PEEK, 8'h00, 9'd256));
    send_item(mk(OP_SKIP, 8'h00, 9'd256));

    // --- random phases, several ring sizes ---
    set_capacity(32'd3);
    run_random_phase(12, 1'b1);
    set_capacity(32'd1);
    run_random_phase(12, 1'b0);
    set_capacity(32'd16);
    run_random_phase(12, 1'b0);
    set_capacity(32'd257);
    run_random_phase(12, 1'b0);
    set_capacity(32'($urandom_range(2, 12)));
    run_random_phase(12, 1'b1);
    // back-to-back stretch with no gaps on either side
    set_capacity(32'd64);
    calm = 1'b1;
    run_random_phase(20, 1'b0);
    calm = 1'b0;

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
